>>> src/rfbr_pkg.sv
// Package with constants, codes and a helper function of the rarest-first block request core.
`timescale 1ns / 1ps
package rfbr_pkg;

  localparam int MAX_PEERS   = 16;
  localparam int MAX_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 16384;

  localparam int CMD_W     = 2;
  localparam int PEER_W    = 4;
  localparam int BLK_W     = 6;
  localparam int SIZE_W    = 21;
  localparam int PIDX_W    = $clog2(MAX_PEERS);
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int VOTE_W    = $clog2(MAX_PEERS + 1);
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_ARRIVE  = 2'd1,
    CMD_REJECT  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAJ,
    ST_SCAN
  } state_t;

  // Number of blocks for a metadata size: ceiling division, saturated.
  // An unknown size (zero) counts as a single block.
  function automatic logic [CNT_W-1:0] block_total(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-BLK_SHIFT:0] n;
    n = {1'b0, size[SIZE_W-1:BLK_SHIFT]}
        + {{(SIZE_W-BLK_SHIFT){1'b0}}, |size[BLK_SHIFT-1:0]};
    if (size == '0) begin
      return CNT_W'(1);
    end
    if (n > (SIZE_W-BLK_SHIFT+1)'(MAX_BLOCKS)) begin
      return CNT_W'(MAX_BLOCKS);
    end
    return n[CNT_W-1:0];
  endfunction

endpackage

>>> src/rfbr_in_if.sv
// Request channel interface: command, peer slot, block index and reported size.
`timescale 1ns / 1ps
interface rfbr_in_if;
  import rfbr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [PEER_W-1:0] peer;
  logic [BLK_W-1:0]  block_index;
  logic [SIZE_W-1:0] total_size;

  modport source (output valid, command, peer, block_index, total_size, input ready);
  modport sink (input valid, command, peer, block_index, total_size, output ready);
endinterface

>>> src/rfbr_out_if.sv
// Result channel interface: found flag and chosen block.
`timescale 1ns / 1ps
interface rfbr_out_if;
  import rfbr_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [BLK_W-1:0] chosen_block;

  modport source (output valid, found, chosen_block, input ready);
  modport sink (input valid, found, chosen_block, output ready);
endinterface

>>> src/rfbr_tally.sv
// Shared population count over one flag per peer slot.
`timescale 1ns / 1ps
module rfbr_tally (
  input  logic [rfbr_pkg::MAX_PEERS-1:0] flags,
  output logic [rfbr_pkg::VOTE_W-1:0]    count
);
  import rfbr_pkg::*;

  always_comb begin
    count = '0;
    for (int q = 0; q < MAX_PEERS; q++) begin
      count = count + {{(VOTE_W-1){1'b0}}, flags[q]};
    end
  end
endmodule

>>> src/rarest_first_block_request_core.sv
// Top level of the rarest-first block request core: peer table and request sequencer.
//
//   Channel  Direction  Transaction contents
//   in_ch    sink       command, peer, block_index, total_size
//   out_ch   source     found, chosen_block
//   cfg      write      cfg_we, cfg_wdata (metadata_known)
//
// An arrival or rejection is decoded in ST_DECODE, which registers its result.
// A request goes from ST_DECODE to ST_SCAN, which scans N = 1..64 blocks one per cycle,
// after a majority-size walk over the 16 peer slots in ST_MAJ when the peer's size is unknown.
// Both walks share one population-count unit over the peer slots.
// Reset is synchronous and clears the whole peer table at once.
// A new transaction is taken only once the previous result has left.
`timescale 1ns / 1ps
module rarest_first_block_request_core (
  input logic   clk,
  input logic   rst_n,
  input logic   cfg_we,
  input logic   cfg_wdata,
  rfbr_in_if.sink    in_ch,
  rfbr_out_if.source out_ch
);
  import rfbr_pkg::*;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]     peer_size_r [MAX_PEERS];
  logic [SIZE_W-1:0]     peer_size_nxt [MAX_PEERS];
  logic [MAX_PEERS-1:0]  peer_rej_r, peer_rej_nxt;
  logic [MAX_BLOCKS-1:0] peer_blocks_r [MAX_PEERS];
  logic [MAX_BLOCKS-1:0] peer_blocks_nxt [MAX_PEERS];
  logic                  active_r, active_nxt;
  logic                  meta_known_r;

  cmd_t              cmd_r;
  logic [CMD_W-1:0]  cmd_raw_r;
  logic [PIDX_W-1:0] peer_r;
  logic [BLK_W-1:0]  blk_in_r;
  logic [SIZE_W-1:0] size_in_r;

  logic [PIDX_W-1:0] idx_r, idx_nxt;
  logic [SIZE_W-1:0] best_size_r, best_size_nxt;
  logic [VOTE_W-1:0] best_votes_r, best_votes_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  blk_r, blk_nxt;
  logic [VOTE_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [BLK_W-1:0]  best_blk_r, best_blk_nxt;
  logic              have_r, have_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [BLK_W-1:0]  out_blk_r, out_blk_nxt;

  logic [SIZE_W-1:0]    size_rd;
  logic [MAX_PEERS-1:0] match_vec;
  logic [MAX_PEERS-1:0] col_vec;
  logic [MAX_PEERS-1:0] tally_in;
  logic [VOTE_W-1:0]    tally;
  logic [BLK_W-1:0]     scan_idx;
  logic                 in_take;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign size_rd  = peer_size_r[idx_r];
  assign scan_idx = blk_r[BLK_W-1:0];

  always_comb begin
    for (int q = 0; q < MAX_PEERS; q++) begin
      match_vec[q] = !peer_rej_r[q] && (peer_size_r[q] == size_rd);
      col_vec[q]   = peer_blocks_r[q][scan_idx];
    end
  end

  // The one count unit serves the vote walk and the block scan in turn.
  assign tally_in = (state_r == ST_MAJ) ? match_vec : col_vec;

  rfbr_tally u_tally (
    .flags (tally_in),
    .count (tally)
  );

  assign in_ch.ready         = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.chosen_block = out_blk_r;

  always_comb begin
    logic elig;
    logic lack;
    logic better;
    logic fin_found;
    logic [BLK_W-1:0] fin_blk;
    logic [SIZE_W-1:0] maj_size;

    state_nxt      = state_r;
    peer_size_nxt  = peer_size_r;
    peer_rej_nxt   = peer_rej_r;
    peer_blocks_nxt = peer_blocks_r;
    active_nxt     = active_r;
    idx_nxt        = idx_r;
    best_size_nxt  = best_size_r;
    best_votes_nxt = best_votes_r;
    cnt_nxt        = cnt_r;
    blk_nxt        = blk_r;
    best_cnt_nxt   = best_cnt_r;
    best_blk_nxt   = best_blk_r;
    have_nxt       = have_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_blk_nxt    = out_blk_r;
    elig           = 1'b0;
    lack           = 1'b0;
    better         = 1'b0;
    fin_found      = 1'b0;
    fin_blk        = '0;
    maj_size       = best_size_r;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          idx_nxt   = peer_r;
          idx_nxt   = in_ch.peer[PIDX_W-1:0];
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        out_found_nxt  = 1'b0;
        out_blk_nxt    = '0;
        state_nxt      = ST_IDLE;
        out_valid_nxt  = 1'b1;
        blk_nxt        = '0;
        have_nxt       = 1'b0;
        best_cnt_nxt   = '0;
        best_blk_nxt   = '0;
        best_size_nxt  = '0;
        best_votes_nxt = '0;
        case (cmd_raw_r)
          CMD_REQUEST: begin
            if (!meta_known_r) begin
              active_nxt = 1'b1;
              if (!peer_rej_r[peer_r]) begin
                out_valid_nxt = 1'b0;
                if (size_rd != '0) begin
                  cnt_nxt   = block_total(size_rd);
                  state_nxt = ST_SCAN;
                end else begin
                  idx_nxt   = '0;
                  state_nxt = ST_MAJ;
                end
              end
            end
          end
          CMD_ARRIVE: begin
            if (active_r) begin
              if (!peer_rej_r[peer_r] && size_rd == '0) begin
                peer_size_nxt[peer_r] = size_in_r;
              end
              if ({1'b0, blk_in_r} < (BLK_W+1)'(MAX_BLOCKS)) begin
                peer_blocks_nxt[peer_r][blk_in_r] = 1'b1;
              end
            end
          end
          CMD_REJECT: begin
            if (active_r) begin
              peer_rej_nxt[peer_r]    = 1'b1;
              peer_size_nxt[peer_r]   = '0;
              peer_blocks_nxt[peer_r] = '0;
            end
          end
          default: begin
          end
        endcase
      end

      ST_MAJ: begin
        elig = !peer_rej_r[idx_r] && (size_rd != '0);
        if (elig && ((tally > best_votes_r) ||
                     ((tally == best_votes_r) && (size_rd > best_size_r)))) begin
          best_votes_nxt = tally;
          best_size_nxt  = size_rd;
          maj_size       = size_rd;
        end
        idx_nxt = idx_r + PIDX_W'(1);
        if (idx_r == PIDX_W'(MAX_PEERS - 1)) begin
          cnt_nxt   = block_total(maj_size);
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        lack   = !peer_blocks_r[peer_r][scan_idx];
        better = lack && (!have_r || (tally < best_cnt_r));
        fin_found = have_r;
        fin_blk   = best_blk_r;
        if (better) begin
          have_nxt     = 1'b1;
          best_cnt_nxt = tally;
          best_blk_nxt = scan_idx;
          fin_found    = 1'b1;
          fin_blk      = scan_idx;
        end
        blk_nxt = blk_r + CNT_W'(1);
        if (blk_r + CNT_W'(1) == cnt_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = fin_found;
          out_blk_nxt   = fin_found ? fin_blk : '0;
          if (fin_found) begin
            peer_blocks_nxt[peer_r][fin_blk] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      peer_rej_r   <= '0;
      active_r     <= 1'b0;
      meta_known_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int q = 0; q < MAX_PEERS; q++) begin
        peer_size_r[q]   <= '0;
        peer_blocks_r[q] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      peer_rej_r    <= peer_rej_nxt;
      active_r      <= active_nxt;
      out_valid_r   <= out_valid_nxt;
      peer_size_r   <= peer_size_nxt;
      peer_blocks_r <= peer_blocks_nxt;
      if (cfg_we) begin
        meta_known_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_raw_r <= in_ch.command;
      cmd_r     <= cmd_t'(in_ch.command);
      peer_r    <= in_ch.peer[PIDX_W-1:0];
      blk_in_r  <= in_ch.block_index;
      size_in_r <= in_ch.total_size;
    end
    idx_r        <= idx_nxt;
    best_size_r  <= best_size_nxt;
    best_votes_r <= best_votes_nxt;
    cnt_r        <= cnt_nxt;
    blk_r        <= blk_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_blk_r   <= best_blk_nxt;
    have_r       <= have_nxt;
    out_found_r  <= out_found_nxt;
    out_blk_r    <= out_blk_nxt;
  end

`ifndef ASSERT_OFF
  // A chosen block lies inside the block count used for the scan.
  a_chosen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r && (cmd_r == CMD_REQUEST))
      |-> ({1'b0, out_blk_r} < cnt_r))
    else $error("chosen block beyond block count");

  // A block handed out is recorded as requested from that peer.
  a_chosen_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_found_r) |-> peer_blocks_r[peer_r][out_blk_r])
    else $error("chosen block not marked for the peer");

  // Once started, the exchange never stops.
  a_active_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(active_r))
    else $error("exchange_active fell");

  // No transaction is taken while a result is still waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !out_valid_r && (state_r == ST_DECODE))
    else $error("transaction taken with result pending");
`endif
endmodule

>>> verif/rarest_first_block_request_core_tb.sv
// Testbench for the rarest-first block request core: random traffic checked against a peer table model.
`timescale 1ns / 1ps
module rarest_first_block_request_core_tb;
  import rfbr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [SIZE_W-1:0] SIZE_ALL_ONES = {SIZE_W{1'b1}};
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 250;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PEER_W-1:0] peer;
    logic [BLK_W-1:0]  block_index;
    logic [SIZE_W-1:0] total_size;
  } block_cmd_t;

  typedef struct packed {
    logic             found;
    logic [BLK_W-1:0] chosen_block;
  } block_grant_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  rfbr_in_if  in_ch();
  rfbr_out_if out_ch();

  rarest_first_block_request_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the peer table.
  logic [SIZE_W-1:0]     peer_size [MAX_PEERS];
  logic                  peer_rejected [MAX_PEERS];
  logic [MAX_BLOCKS-1:0] peer_held [MAX_PEERS];
  logic                  exchange_on;
  logic                  meta_known;

  block_cmd_t   cmd_backlog[$];
  block_grant_t pending_grants[$];
  block_cmd_t   cur_cmd;
  logic         offering;
  int           send_gap;
  int           stall_left;
  logic         hold_off_req;
  logic         steady;
  int           error_count;
  int           quiet_cycles;

  always #5 clk = ~clk;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SIZE_W-1:0] majority_size();
    logic [SIZE_W-1:0] best_size;
    int best_votes;
    int votes;
    best_size  = '0;
    best_votes = 0;
    for (int a = 0; a < MAX_PEERS; a++) begin
      if (!peer_rejected[a] && peer_size[a] != '0) begin
        votes = 0;
        for (int b = 0; b < MAX_PEERS; b++) begin
          if (!peer_rejected[b] && peer_size[b] == peer_size[a]) begin
            votes++;
          end
        end
        if (votes > best_votes || (votes == best_votes && peer_size[a] > best_size)) begin
          best_votes = votes;
          best_size  = peer_size[a];
        end
      end
    end
    return best_size;
  endfunction

  function automatic int blocks_for(logic [SIZE_W-1:0] size);
    int n;
    if (size == '0) begin
      return 1;
    end
    n = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
  endfunction

  // Lowest-index block with the fewest holders among those the peer lacks, or -1.
  function automatic int rarest_block(int p);
    logic [SIZE_W-1:0] size;
    int n;
    int best;
    int best_cnt;
    int cnt;
    size = peer_size[p];
    if (size == '0) begin
      size = majority_size();
    end
    n        = blocks_for(size);
    best     = -1;
    best_cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (!peer_held[p][i]) begin
        cnt = 0;
        for (int q = 0; q < MAX_PEERS; q++) begin
          cnt += peer_held[q][i];
        end
        if (best < 0 || cnt < best_cnt) begin
          best     = i;
          best_cnt = cnt;
        end
      end
    end
    return best;
  endfunction

  function automatic block_grant_t table_step(block_cmd_t t);
    block_grant_t g;
    int pick;
    g = '0;
    case (t.command)
      CMD_REQUEST: begin
        if (!meta_known) begin
          exchange_on = 1'b1;
          if (!peer_rejected[t.peer]) begin
            pick = rarest_block(t.peer);
            if (pick >= 0) begin
              peer_held[t.peer][pick] = 1'b1;
              g.found        = 1'b1;
              g.chosen_block = pick[BLK_W-1:0];
            end
          end
        end
      end
      CMD_ARRIVE: begin
        if (exchange_on) begin
          if (!peer_rejected[t.peer] && peer_size[t.peer] == '0) begin
            peer_size[t.peer] = t.total_size;
          end
          peer_held[t.peer][t.block_index] = 1'b1;
        end
      end
      CMD_REJECT: begin
        if (exchange_on) begin
          peer_rejected[t.peer] = 1'b1;
          peer_size[t.peer]     = '0;
          peer_held[t.peer]     = '0;
        end
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic queue_cmd(logic [CMD_W-1:0] c, int p, int blk, logic [SIZE_W-1:0] size);
    block_cmd_t t;
    t.command     = c;
    t.peer        = p[PEER_W-1:0];
    t.block_index = blk[BLK_W-1:0];
    t.total_size  = size;
    cmd_backlog.push_back(t);
  endtask

  task automatic write_meta_known(logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    meta_known = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || offering || pending_grants.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  // Mostly coherent traffic: a few shared sizes, blocks near the front, rare rejections.
  task automatic queue_random(int n);
    int r;
    int blk;
    logic [SIZE_W-1:0] size;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        queue_cmd(CMD_REQUEST, $urandom_range(0, 15), $urandom_range(0, 63),
                  SIZE_W'($urandom));
      end else if (r < 94) begin
        r = $urandom_range(0, 99);
        if (r < 45) size = 21'd50000;
        else if (r < 70) size = 21'd200000;
        else if (r < 80) size = 21'd49152;
        else if (r < 88) size = 21'd1048576;
        else if (r < 94) size = '0;
        else size = SIZE_W'($urandom_range(1, int'(SIZE_ALL_ONES)));
        blk = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 63);
        queue_cmd(CMD_ARRIVE, $urandom_range(0, 15), blk, size);
      end else if (r < 96) begin
        queue_cmd(CMD_REJECT, $urandom_range(8, 15), $urandom_range(0, 63),
                  SIZE_W'($urandom));
      end else begin
        queue_cmd(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 63),
                  SIZE_W'($urandom));
      end
    end
  endtask

  // Driver: offers the backlog one transaction at a time with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (offering && in_ch.ready) begin
        pending_grants.push_back(table_step(cur_cmd));
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() != 0) begin
          cur_cmd  = cmd_backlog.pop_front();
          offering = 1'b1;
          send_gap = draw_gap();
        end
      end
    end
    in_ch.valid       <= offering;
    in_ch.command     <= cur_cmd.command;
    in_ch.peer        <= cur_cmd.peer;
    in_ch.block_index <= cur_cmd.block_index;
    in_ch.total_size  <= cur_cmd.total_size;
  end

  // Monitor: checks each result transaction and throttles ready.
  always @(posedge clk) begin
    block_grant_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("unexpected result, found", out_ch.found, 0);
        end else begin
          want = pending_grants.pop_front();
          if (out_ch.found !== want.found) begin
            report_mismatch("found", out_ch.found, want.found);
          end
          if (out_ch.chosen_block !== want.chosen_block) begin
            report_mismatch("chosen_block", out_ch.chosen_block, want.chosen_block);
          end
        end
      end
      if (hold_off_req) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = draw_gap();
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = '0;
    in_ch.peer        = '0;
    in_ch.block_index = '0;
    in_ch.total_size  = '0;
    out_ch.ready      = 1'b0;
    cur_cmd           = '0;
    offering          = 1'b0;
    send_gap          = 0;
    stall_left        = 0;
    hold_off_req      = 1'b0;
    steady            = 1'b0;
    error_count       = 0;
    quiet_cycles      = 0;
    meta_known        = 1'b0;
    exchange_on       = 1'b0;
    for (int p = 0; p < MAX_PEERS; p++) begin
      peer_size[p]     = '0;
      peer_rejected[p] = 1'b0;
      peer_held[p]     = '0;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // With metadata complete nothing activates the exchange, so the rest is ignored too.
    write_meta_known(1'b1);
    queue_cmd(CMD_REQUEST, 0, 0, '0);
    queue_cmd(CMD_ARRIVE, 1, 5, 21'd50000);
    queue_cmd(CMD_REJECT, 2, 0, '0);
    queue_cmd(CMD_UNUSED, 3, 0, '0);
    drain();

    write_meta_known(1'b0);
    queue_cmd(CMD_REQUEST, 0, 0, '0);
    queue_cmd(CMD_REQUEST, 0, 0, '0);
    queue_cmd(CMD_ARRIVE, 1, 63, 21'd1048576);
    queue_cmd(CMD_ARRIVE, 2, 0, '0);
    queue_cmd(CMD_ARRIVE, 3, 10, SIZE_ALL_ONES);
    queue_cmd(CMD_ARRIVE, 4, 1, 21'd16385);
    queue_cmd(CMD_REQUEST, 2, 0, '0);
    queue_cmd(CMD_REQUEST, 4, 0, '0);
    queue_cmd(CMD_REQUEST, 4, 0, '0);
    queue_cmd(CMD_REJECT, 3, 0, '0);
    queue_cmd(CMD_REQUEST, 3, 0, '0);
    queue_cmd(CMD_ARRIVE, 3, 7, 21'd100);
    queue_cmd(CMD_REQUEST, 15, 0, '0);
    queue_cmd(CMD_ARRIVE, 15, 0, 21'd1);
    queue_cmd(CMD_REQUEST, 15, 0, '0);
    queue_cmd(CMD_UNUSED, 5, 63, SIZE_ALL_ONES);
    queue_cmd(CMD_ARRIVE, 5, 0, 21'd16384);
    queue_cmd(CMD_REQUEST, 6, 0, '0);
    queue_cmd(CMD_REQUEST, 1, 0, '0);
    drain();

    queue_random(140);
    drain();

    write_meta_known(1'b1);
    steady = 1'b1;
    queue_random(40);
    drain();

    // The receiver holds off for a long stretch while the sender keeps offering.
    write_meta_known(1'b0);
    steady = 1'b0;
    queue_random(150);
    hold_off_req = 1'b1;
    drain();

    steady = 1'b1;
    queue_random(70);
    drain();

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rfbr_pkg.sv
src/rfbr_in_if.sv
src/rfbr_out_if.sv
src/rfbr_tally.sv
src/rarest_first_block_request_core.sv
verif/rarest_first_block_request_core_tb.sv
